// ----- design/direct_mapped_writeback_cache_core_assert.svh -----
// Assertion macros used by the checker file of the cache core.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_CORE_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache core assertion failed");

`endif

// ----- design/dmc_pkg.sv -----
package dmc_pkg;

    localparam int DefLineCount   = 256;
    localparam int DefLineBytes   = 64;
    localparam int DefWordBytes   = 4;
    localparam int DefMemoryBytes = 1048576;
    localparam int QueueDepth     = 2;

    localparam logic [15:0] RstMemReadLat   = 16'd100;
    localparam logic [15:0] RstMemWriteLat  = 16'd50;
    localparam logic [15:0] RstCacheReadLat = 16'd1;
    localparam logic [15:0] RstCacheWriteLat = 16'd1;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_e;

    typedef enum logic [1:0] {
        CFG_MEM_READ_LAT    = 2'd0,
        CFG_MEM_WRITE_LAT   = 2'd1,
        CFG_CACHE_READ_LAT  = 2'd2,
        CFG_CACHE_WRITE_LAT = 2'd3
    } cfg_index_e;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_TAG,
        BK_READ,
        BK_WB,
        BK_FILL,
        BK_FINISH
    } back_state_e;

    typedef struct packed {
        op_e         op;
        logic [31:0] address;
        logic [31:0] write_word;
    } request_t;

    typedef struct packed {
        logic [31:0] read_word;
        logic        hit;
        logic        wrote_back;
        logic        out_of_range;
        logic [31:0] elapsed_time;
    } result_t;

    typedef struct packed {
        request_t req;
        logic     oor;
    } q_entry_t;

    typedef struct packed {
        logic [15:0] mem_read_latency;
        logic [15:0] mem_write_latency;
        logic [15:0] cache_read_latency;
        logic [15:0] cache_write_latency;
    } latency_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

// ----- design/direct_mapped_writeback_cache_core.sv -----
// Direct-mapped write-back, write-allocate cache with its backing memory inside. A transaction
// is taken when start is high and busy is low; its result shows on result for exactly one
// cycle with done high and cannot be held off. Up to two transactions wait in a queue while
// the back end works. A miss adds a 16-word line fill (at the default sizes) and, with a dirty
// victim, a write-back of the victim line, both set by the one read port of the cache and
// memory arrays moving a single word per cycle.
// After reset the backing memory is cleared one word per cycle (262144 words at the default
// size) and busy stays high until that is done; configuration writes are taken at any time.
module direct_mapped_writeback_cache_core
    import dmc_pkg::*;
#(
    parameter int LINE_COUNT   = DefLineCount,
    parameter int LINE_BYTES   = DefLineBytes,
    parameter int WORD_BYTES   = DefWordBytes,
    parameter int MEMORY_BYTES = DefMemoryBytes
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  request_t    request,
    output logic        done,
    output result_t     result,
    input  logic        cfg_write,
    input  cfg_index_e  cfg_index,
    input  logic [15:0] cfg_data
);

    latency_t  latency_reg;
    q_status_t q_status;
    q_entry_t  push_entry, q_head;
    logic      push, pop, clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latency_reg.mem_read_latency    <= RstMemReadLat;
            latency_reg.mem_write_latency   <= RstMemWriteLat;
            latency_reg.cache_read_latency  <= RstCacheReadLat;
            latency_reg.cache_write_latency <= RstCacheWriteLat;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MEM_READ_LAT:    latency_reg.mem_read_latency    <= cfg_data;
                CFG_MEM_WRITE_LAT:   latency_reg.mem_write_latency   <= cfg_data;
                CFG_CACHE_READ_LAT:  latency_reg.cache_read_latency  <= cfg_data;
                CFG_CACHE_WRITE_LAT: latency_reg.cache_write_latency <= cfg_data;
                default:             latency_reg <= latency_reg;
            endcase
        end
    end

    dmc_front #(.MEMORY_BYTES(MEMORY_BYTES)) u_front (
        .start      (start),
        .request    (request),
        .q_status   (q_status),
        .clearing   (clearing),
        .busy       (busy),
        .push       (push),
        .push_entry (push_entry)
    );

    dmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (q_head),
        .status     (q_status)
    );

    dmc_back #(
        .LINE_COUNT   (LINE_COUNT),
        .LINE_BYTES   (LINE_BYTES),
        .WORD_BYTES   (WORD_BYTES),
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .latency  (latency_reg),
        .q_status (q_status),
        .q_head   (q_head),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

endmodule

// ----- design/dmc_ram.sv -----
module dmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/dmc_queue.sv -----
module dmc_queue
    import dmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t status
);

    localparam int PtrW = $clog2(QueueDepth);

    q_entry_t          entries_reg [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head             = entries_reg[rd_ptr_reg];
    assign status.full      = (count_reg == (PtrW+1)'(QueueDepth));
    assign status.not_empty = (count_reg != '0);

endmodule

// ----- design/dmc_front.sv -----
module dmc_front
    import dmc_pkg::*;
#(
    parameter int MEMORY_BYTES = DefMemoryBytes
) (
    input  logic      start,
    input  request_t  request,
    input  q_status_t q_status,
    input  logic      clearing,
    output logic      busy,
    output logic      push,
    output q_entry_t  push_entry
);

    assign busy           = q_status.full || clearing;
    assign push           = start && !busy;
    assign push_entry.req = request;
    // Accesses past the end of backing memory are flagged here and never touch the cache or memory.
    assign push_entry.oor = (request.address >= 32'(MEMORY_BYTES));

endmodule

// ----- design/dmc_back.sv -----
module dmc_back
    import dmc_pkg::*;
#(
    parameter int LINE_COUNT   = DefLineCount,
    parameter int LINE_BYTES   = DefLineBytes,
    parameter int WORD_BYTES   = DefWordBytes,
    parameter int MEMORY_BYTES = DefMemoryBytes
) (
    input  logic      clk,
    input  logic      rst_n,
    input  latency_t  latency,
    input  q_status_t q_status,
    input  q_entry_t  q_head,
    output logic      pop,
    output logic      clearing,
    output logic      done,
    output result_t   result
);

    localparam int Wpl     = LINE_BYTES / WORD_BYTES;
    localparam int MemWords = MEMORY_BYTES / WORD_BYTES;
    localparam int WbW     = $clog2(WORD_BYTES);
    localparam int OffW    = $clog2(LINE_BYTES);
    localparam int WoW     = $clog2(Wpl);
    localparam int IdxW    = $clog2(LINE_COUNT);
    localparam int AddrW   = $clog2(MEMORY_BYTES);
    localparam int TagW    = AddrW - OffW - IdxW;
    localparam int LnW     = AddrW - OffW;
    localparam int MwW     = $clog2(MemWords);
    localparam int DaW     = IdxW + WoW;
    localparam logic [MwW:0]  MemWordsL = (MwW+1)'(MemWords);
    localparam logic [WoW:0]  WplL      = (WoW+1)'(Wpl);

    back_state_e          state_reg, state_next;
    q_entry_t             cur_reg, cur_next;
    logic [WoW:0]         cnt_reg, cnt_next;
    logic [31:0]          time_reg, time_next;
    logic                 hit_reg, hit_next;
    logic                 wb_reg, wb_next;
    logic [31:0]          rdata_reg, rdata_next;
    logic [TagW-1:0]      vtag_reg, vtag_next;
    logic [MwW-1:0]       clr_reg, clr_next;
    logic [LINE_COUNT-1:0] valid_reg, valid_next;
    logic [LINE_COUNT-1:0] dirty_reg, dirty_next;
    logic                 done_reg, done_next;
    result_t              result_reg, result_next;
    logic [15:0]          add_sel;
    logic                 emit;

    logic                 tag_we;
    logic [IdxW-1:0]      tag_waddr, tag_raddr;
    logic [TagW-1:0]      tag_rdata;
    logic                 dat_we;
    logic [DaW-1:0]       dat_waddr, dat_raddr;
    logic [31:0]          dat_wdata, dat_rdata;
    logic                 mem_we;
    logic [MwW-1:0]       mem_waddr, mem_raddr;
    logic [31:0]          mem_wdata, mem_rdata;

    logic [IdxW-1:0]      cur_idx;
    logic [TagW-1:0]      cur_tag;
    logic [WoW-1:0]       cur_woff;
    logic [LnW-1:0]       cur_line;
    logic [WoW-1:0]       cw, pw;
    logic [MwW-1:0]       wb_addr, fill_addr;
    logic                 line_hit;

    assign cur_idx  = cur_reg.req.address[OffW +: IdxW];
    assign cur_tag  = cur_reg.req.address[OffW+IdxW +: TagW];
    assign cur_woff = cur_reg.req.address[WbW +: WoW];
    assign cur_line = cur_reg.req.address[OffW +: LnW];
    assign cw       = cnt_reg[WoW-1:0];
    assign pw       = cw - 1'b1;
    assign wb_addr  = {vtag_reg, cur_idx, pw};
    assign fill_addr = {cur_line, pw};
    assign line_hit = valid_reg[cur_idx] && (tag_rdata == cur_tag);
    assign tag_raddr = q_head.req.address[OffW +: IdxW];

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        hit_next    = hit_reg;
        wb_next     = wb_reg;
        rdata_next  = rdata_reg;
        vtag_next   = vtag_reg;
        clr_next    = clr_reg;
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        result_next = result_reg;
        add_sel     = '0;
        emit        = 1'b0;
        pop         = 1'b0;
        tag_we      = 1'b0;
        tag_waddr   = cur_idx;
        dat_we      = 1'b0;
        dat_waddr   = {cur_idx, cur_woff};
        dat_wdata   = cur_reg.req.write_word;
        dat_raddr   = {cur_idx, cur_woff};
        mem_we      = 1'b0;
        mem_waddr   = wb_addr;
        mem_wdata   = dat_rdata;
        mem_raddr   = {cur_line, cw};

        case (state_reg)
            BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == MwW'(MemWords - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    pop      = 1'b1;
                    cur_next = q_head;
                    hit_next = 1'b0;
                    wb_next  = 1'b0;
                    if (q_head.oor)
                    begin
                        emit = 1'b1;
                        result_next.read_word    = '0;
                        result_next.hit          = 1'b0;
                        result_next.wrote_back   = 1'b0;
                        result_next.out_of_range = 1'b1;
                    end
                    else
                    begin
                        state_next = BK_TAG;
                    end
                end
            end
            BK_TAG:
            begin
                vtag_next = tag_rdata;
                cnt_next  = '0;
                if (line_hit)
                begin
                    hit_next = 1'b1;
                    if (cur_reg.req.op == OP_WRITE)
                    begin
                        dat_we  = 1'b1;
                        dirty_next[cur_idx] = 1'b1;
                        add_sel = latency.cache_write_latency;
                        emit    = 1'b1;
                        result_next.read_word    = '0;
                        result_next.hit          = 1'b1;
                        result_next.wrote_back   = 1'b0;
                        result_next.out_of_range = 1'b0;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        state_next = BK_READ;
                    end
                end
                else if (valid_reg[cur_idx] && dirty_reg[cur_idx])
                begin
                    wb_next    = 1'b1;
                    add_sel    = latency.mem_write_latency;
                    state_next = BK_WB;
                end
                else
                begin
                    state_next = BK_FILL;
                end
            end
            BK_READ:
            begin
                add_sel = latency.cache_read_latency;
                emit    = 1'b1;
                result_next.read_word    = dat_rdata;
                result_next.hit          = hit_reg;
                result_next.wrote_back   = wb_reg;
                result_next.out_of_range = 1'b0;
                state_next = BK_IDLE;
            end
            BK_WB:
            begin
                // Cache word cw is read this cycle and lands in memory the next.
                dat_raddr = {cur_idx, cw};
                if (cnt_reg != '0)
                begin
                    mem_we = ({1'b0, wb_addr} < MemWordsL);
                end
                if (cnt_reg == WplL)
                begin
                    cnt_next   = '0;
                    state_next = BK_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            BK_FILL:
            begin
                dat_waddr = {cur_idx, pw};
                dat_wdata = ({1'b0, fill_addr} < MemWordsL) ? mem_rdata : '0;
                if (cnt_reg != '0)
                begin
                    dat_we = 1'b1;
                    if (pw == cur_woff)
                    begin
                        rdata_next = dat_wdata;
                    end
                end
                if (cnt_reg == WplL)
                begin
                    add_sel    = latency.mem_read_latency;
                    state_next = BK_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            BK_FINISH:
            begin
                tag_we = 1'b1;
                valid_next[cur_idx] = 1'b1;
                dirty_next[cur_idx] = (cur_reg.req.op == OP_WRITE);
                emit = 1'b1;
                result_next.hit          = 1'b0;
                result_next.wrote_back   = wb_reg;
                result_next.out_of_range = 1'b0;
                if (cur_reg.req.op == OP_WRITE)
                begin
                    dat_we  = 1'b1;
                    add_sel = latency.cache_write_latency;
                    result_next.read_word = '0;
                end
                else
                begin
                    add_sel = latency.cache_read_latency;
                    result_next.read_word = rdata_reg;
                end
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        time_next = time_reg + {16'd0, add_sel};
        done_next = emit;
        if (emit)
        begin
            result_next.elapsed_time = time_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            time_reg  <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            time_reg  <= time_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        cnt_reg    <= cnt_next;
        hit_reg    <= hit_next;
        wb_reg     <= wb_next;
        rdata_reg  <= rdata_next;
        vtag_reg   <= vtag_next;
        result_reg <= result_next;
    end

    dmc_ram #(.WIDTH(TagW), .DEPTH(LINE_COUNT)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (cur_tag),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    dmc_ram #(.WIDTH(32), .DEPTH(LINE_COUNT * Wpl)) u_data_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (dat_wdata),
        .raddr (dat_raddr),
        .rdata (dat_rdata)
    );

    dmc_ram #(.WIDTH(32), .DEPTH(MemWords)) u_backing_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign clearing = (state_reg == BK_CLEAR);
    assign done     = done_reg;
    assign result   = result_reg;

endmodule

// ----- design/dmc_checker.sv -----
`include "direct_mapped_writeback_cache_core_assert.svh"

module dmc_checker
    import dmc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input result_t     result
);

    logic [31:0] last_time_reg;
    logic        oor_done;

    assign oor_done = done && result.out_of_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
        end
        else if (done)
        begin
            last_time_reg <= result.elapsed_time;
        end
    end

    // An ignored access reports nothing but the flag.
    `DMC_ASSERT_SAME(a_oor_quiet, oor_done, !result.hit && !result.wrote_back && result.read_word == '0)
    // A victim is only written back on a miss.
    `DMC_ASSERT_SAME(a_wb_on_miss, done && result.wrote_back, !result.hit)
    // An ignored access leaves the time counter where the last transaction left it.
    `DMC_ASSERT_SAME(a_oor_time, oor_done, result.elapsed_time == last_time_reg)
    // A hit always lies inside backing memory.
    `DMC_ASSERT_SAME(a_hit_in_range, done && result.hit, !result.out_of_range)

endmodule

bind direct_mapped_writeback_cache_core dmc_checker u_dmc_checker (.*);
